>>> design/euler_xyz_point_rotator_defines.svh
// ---------------------------------------------------------------------------
// Euler XYZ point rotator assertion macros
// Shared macros for the concurrent checks that are bound to the rotator.
// ---------------------------------------------------------------------------
`ifndef EULER_XYZ_POINT_ROTATOR_DEFINES_SVH
`define EULER_XYZ_POINT_ROTATOR_DEFINES_SVH

// Check that is switched off while reset is held.
`define EUL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs while reset is held.
`define EUL_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/eul_pkg.sv
// ---------------------------------------------------------------------------
// Euler rotator package
// Widths, register codes and shared types of the Euler XYZ point rotator.
// ---------------------------------------------------------------------------
package eul_pkg;

  // Field widths.
  localparam int PtW    = 32;  // Q16.16 coordinate on the ports
  localparam int TrigW  = 16;  // Q2.14 sine or cosine
  localparam int ScaleW = 16;  // Q8.8 unsigned scale
  localparam int OpW    = 2;
  localparam int CoordW = 48;  // internal coordinate, unsaturated
  localparam int ProdW  = 64;  // coordinate times trig value
  localparam int DataW  = 32;  // configuration data bus

  // Configuration address map: register i at byte address 4*i.
  localparam int NumRegs = 7;
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 2;

  // Rounding constants.
  localparam int TrigFrac  = 14;
  localparam int ScaleFrac = 8;
  localparam logic [ScaleW-1:0] UnitScale = ScaleW'(1 << ScaleFrac);

  // Saturation bounds of the Q16.16 result.
  localparam logic signed [CoordW-1:0] SatMax = CoordW'(64'sh7FFF_FFFF);
  localparam logic signed [CoordW-1:0] SatMin = -CoordW'(64'sh8000_0000);

  // Number of register stages from input word to result word.
  localparam int PipeDepth = 9;
  localparam int CntW      = 4;

  // Register indexes.
  typedef enum logic [RegIdxW-1:0] {
    REG_COS_X,
    REG_SIN_X,
    REG_COS_Y,
    REG_SIN_Y,
    REG_COS_Z,
    REG_SIN_Z,
    REG_SCALE
  } reg_idx_t;

  // Rotation axis handled by one rotation stage.
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Configuration register contents.
  typedef struct packed {
    logic signed [TrigW-1:0] cos_x;
    logic signed [TrigW-1:0] sin_x;
    logic signed [TrigW-1:0] cos_y;
    logic signed [TrigW-1:0] sin_y;
    logic signed [TrigW-1:0] cos_z;
    logic signed [TrigW-1:0] sin_z;
    logic [ScaleW-1:0]       scale;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    cos_x: TrigW'(16384),
    sin_x: '0,
    cos_y: TrigW'(16384),
    sin_y: '0,
    cos_z: TrigW'(16384),
    sin_z: '0,
    scale: UnitScale
  };

  // Word travelling down the pipeline.
  typedef struct packed {
    logic [OpW-1:0]           op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic signed [PtW-1:0]    ox;
    logic signed [PtW-1:0]    oy;
    logic signed [PtW-1:0]    oz;
  } item_t;

endpackage

>>> design/eul_stream_if.sv
// ---------------------------------------------------------------------------
// Euler rotator stream interfaces
// Valid/ready channels for input points and rotated results.
// ---------------------------------------------------------------------------

// Input point channel.
interface eul_pt_if;
  import eul_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OpW-1:0]        operation;
  logic signed [PtW-1:0] point_x;
  logic signed [PtW-1:0] point_y;
  logic signed [PtW-1:0] point_z;
  logic signed [PtW-1:0] offset_x;
  logic signed [PtW-1:0] offset_y;
  logic signed [PtW-1:0] offset_z;

  modport source (
    output valid, operation, point_x, point_y, point_z, offset_x, offset_y, offset_z,
    input  ready
  );
  modport sink (
    input  valid, operation, point_x, point_y, point_z, offset_x, offset_y, offset_z,
    output ready
  );
endinterface

// Result channel.
interface eul_res_if;
  import eul_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [PtW-1:0] result_x;
  logic signed [PtW-1:0] result_y;
  logic signed [PtW-1:0] result_z;

  modport source (
    output valid, result_x, result_y, result_z,
    input  ready
  );
  modport sink (
    input  valid, result_x, result_y, result_z,
    output ready
  );
endinterface

>>> design/eul_cfg.sv
// ---------------------------------------------------------------------------
// Euler rotator configuration registers
// APB-style register file holding the trig values and the scale factor.
// ---------------------------------------------------------------------------
module eul_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eul_pkg::AddrW-1:0]  paddr,
  input  logic [eul_pkg::DataW-1:0]  pwdata,
  output logic [eul_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output eul_pkg::cfg_t              cfg
);
  import eul_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (wr_en) begin
      case (idx)
        REG_COS_X: cfg_r.cos_x <= pwdata[TrigW-1:0];
        REG_SIN_X: cfg_r.sin_x <= pwdata[TrigW-1:0];
        REG_COS_Y: cfg_r.cos_y <= pwdata[TrigW-1:0];
        REG_SIN_Y: cfg_r.sin_y <= pwdata[TrigW-1:0];
        REG_COS_Z: cfg_r.cos_z <= pwdata[TrigW-1:0];
        REG_SIN_Z: cfg_r.sin_z <= pwdata[TrigW-1:0];
        REG_SCALE: cfg_r.scale <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_COS_X: prdata[TrigW-1:0]  = cfg_r.cos_x;
      REG_SIN_X: prdata[TrigW-1:0]  = cfg_r.sin_x;
      REG_COS_Y: prdata[TrigW-1:0]  = cfg_r.cos_y;
      REG_SIN_Y: prdata[TrigW-1:0]  = cfg_r.sin_y;
      REG_COS_Z: prdata[TrigW-1:0]  = cfg_r.cos_z;
      REG_SIN_Z: prdata[TrigW-1:0]  = cfg_r.sin_z;
      REG_SCALE: prdata[ScaleW-1:0] = cfg_r.scale;
      default:   prdata = '0;
    endcase
  end

endmodule

>>> design/eul_scale.sv
// ---------------------------------------------------------------------------
// Euler rotator scale stage
// Two pipeline stages: multiply by the scale factor, then round back to
// Q16.16. Words that are not scaled go through a factor of one.
// ---------------------------------------------------------------------------
module eul_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  eul_pkg::item_t             in_item,
  input  logic [eul_pkg::ScaleW-1:0] scale,
  output logic                       out_valid,
  input  logic                       out_ready,
  output eul_pkg::item_t             out_item
);
  import eul_pkg::*;

  logic                      a_vld_r;
  item_t                     a_item_r;
  logic signed [CoordW-1:0]  a_px_r, a_py_r, a_pz_r;
  logic signed [CoordW-1:0]  px_nxt, py_nxt, pz_nxt;
  logic [ScaleW-1:0]         fac;
  logic                      b_vld_r;
  item_t                     b_item_r;
  item_t                     b_item_nxt;
  logic                      b_rdy;

  // Per-stage flow control.
  assign b_rdy    = !b_vld_r || out_ready;
  assign in_ready = !a_vld_r || b_rdy;

  // Multiply stage.
  always_comb begin
    fac    = in_item.op[1] ? scale : UnitScale;
    px_nxt = $signed(in_item.x[PtW-1:0]) * $signed({1'b0, fac});
    py_nxt = $signed(in_item.y[PtW-1:0]) * $signed({1'b0, fac});
    pz_nxt = $signed(in_item.z[PtW-1:0]) * $signed({1'b0, fac});
  end

  // Round half up back to Q16.16.
  always_comb begin
    b_item_nxt   = a_item_r;
    b_item_nxt.x = (a_px_r + CoordW'(128)) >>> ScaleFrac;
    b_item_nxt.y = (a_py_r + CoordW'(128)) >>> ScaleFrac;
    b_item_nxt.z = (a_pz_r + CoordW'(128)) >>> ScaleFrac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_vld_r <= in_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_item_r <= in_item;
      a_px_r   <= px_nxt;
      a_py_r   <= py_nxt;
      a_pz_r   <= pz_nxt;
    end
    if (b_rdy && a_vld_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_item  = b_item_r;

endmodule

>>> design/eul_rot.sv
// ---------------------------------------------------------------------------
// Euler rotator axis stage
// Rotates one coordinate pair about the selected axis in two pipeline
// stages: four products, then two sums rounded back to Q16.16.
// ---------------------------------------------------------------------------
module eul_rot (
  input  logic                            clk,
  input  logic                            rst_n,
  input  eul_pkg::axis_t                  axis,
  input  logic signed [eul_pkg::TrigW-1:0] cos_v,
  input  logic signed [eul_pkg::TrigW-1:0] sin_v,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  eul_pkg::item_t                  in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output eul_pkg::item_t                  out_item
);
  import eul_pkg::*;

  logic signed [CoordW-1:0] a, b;
  logic signed [ProdW-1:0]  ac_nxt, bs_nxt, as_nxt, bc_nxt;
  logic signed [ProdW-1:0]  ac_r, bs_r, as_r, bc_r;
  logic signed [ProdW-1:0]  u_sum, v_sum;
  logic                     a_vld_r;
  item_t                    a_item_r;
  logic                     b_vld_r;
  item_t                    b_item_r;
  item_t                    b_item_nxt;
  logic                     b_rdy;

  assign b_rdy    = !b_vld_r || out_ready;
  assign in_ready = !a_vld_r || b_rdy;

  // Pick the coordinate pair turned by this axis.
  always_comb begin
    case (axis)
      AXIS_X: begin
        a = in_item.y;
        b = in_item.z;
      end
      AXIS_Y: begin
        a = in_item.x;
        b = in_item.z;
      end
      default: begin
        a = in_item.x;
        b = in_item.y;
      end
    endcase
    ac_nxt = a * cos_v;
    bs_nxt = b * sin_v;
    as_nxt = a * sin_v;
    bc_nxt = b * cos_v;
  end

  // Sum the products and round half up.
  always_comb begin
    u_sum      = (ac_r - bs_r + ProdW'(1 << (TrigFrac - 1))) >>> TrigFrac;
    v_sum      = (as_r + bc_r + ProdW'(1 << (TrigFrac - 1))) >>> TrigFrac;
    b_item_nxt = a_item_r;
    case (axis)
      AXIS_X: begin
        b_item_nxt.y = u_sum[CoordW-1:0];
        b_item_nxt.z = v_sum[CoordW-1:0];
      end
      AXIS_Y: begin
        b_item_nxt.x = u_sum[CoordW-1:0];
        b_item_nxt.z = v_sum[CoordW-1:0];
      end
      default: begin
        b_item_nxt.x = u_sum[CoordW-1:0];
        b_item_nxt.y = v_sum[CoordW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_vld_r <= in_valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_item_r <= in_item;
      ac_r     <= ac_nxt;
      bs_r     <= bs_nxt;
      as_r     <= as_nxt;
      bc_r     <= bc_nxt;
    end
    if (b_rdy && a_vld_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign out_item  = b_item_r;

endmodule

>>> design/eul_out.sv
// ---------------------------------------------------------------------------
// Euler rotator output stage
// Adds the offset where the operation asks for it, saturates to Q16.16
// and holds the result word in the output register.
// ---------------------------------------------------------------------------
module eul_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  eul_pkg::item_t                in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [eul_pkg::PtW-1:0] res_x,
  output logic signed [eul_pkg::PtW-1:0] res_y,
  output logic signed [eul_pkg::PtW-1:0] res_z
);
  import eul_pkg::*;

  logic                     vld_r;
  logic signed [PtW-1:0]    res_x_r, res_y_r, res_z_r;
  logic signed [CoordW-1:0] sx, sy, sz;

  function automatic logic signed [PtW-1:0] sat(input logic signed [CoordW-1:0] v);
    logic signed [PtW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[PtW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[PtW-1:0];
    end else begin
      r = v[PtW-1:0];
    end
    return r;
  endfunction

  assign in_ready = !vld_r || out_ready;

  // Offset add; offsets count only in the offset modes.
  always_comb begin
    sx = in_item.x;
    sy = in_item.y;
    sz = in_item.z;
    if (in_item.op[0]) begin
      sx = in_item.x + CoordW'(in_item.ox);
      sy = in_item.y + CoordW'(in_item.oy);
      sz = in_item.z + CoordW'(in_item.oz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_x_r <= sat(sx);
      res_y_r <= sat(sy);
      res_z_r <= sat(sz);
    end
  end

  assign out_valid = vld_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;
  assign res_z     = res_z_r;

endmodule

>>> design/euler_xyz_point_rotator.sv
// ---------------------------------------------------------------------------
// Euler XYZ point rotator
// Rotates Q16.16 points about X, then Y, then Z, with optional uniform
// scaling before and offset addition after the rotation.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Handshake              Word
//   in_ch     in    valid/ready            operation, point_xyz, offset_xyz
//   out_ch    out   valid/ready            result_xyz
//   APB       in    psel/penable/pready    7 registers, 16 bits at 4*i
//
// One word is accepted per cycle while no stall has backed up to the input; each
// word passes through the scaling stages, the stages of each of the three axis
// rotations, then the offset and saturation stage. Every stage has its own valid
// bit and advances when the stage after it is empty or moving, so a stall at the
// output only stops stages that hold words. Reset clears all valid bits and
// loads the identity rotation with a scale of one.
//
module euler_xyz_point_rotator (
  input  logic                      clk,
  input  logic                      rst_n,
  eul_pt_if.sink                    in_ch,
  eul_res_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [eul_pkg::AddrW-1:0] paddr,
  input  logic [eul_pkg::DataW-1:0] pwdata,
  output logic [eul_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import eul_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t sc_item, rx_item, ry_item, rz_item;
  logic  sc_vld, rx_vld, ry_vld, rz_vld;
  logic  sc_rdy, rx_rdy, ry_rdy, rz_rdy;

  // Widen the incoming point to the internal coordinate width.
  always_comb begin
    in_item.op = in_ch.operation;
    in_item.x  = CoordW'(in_ch.point_x);
    in_item.y  = CoordW'(in_ch.point_y);
    in_item.z  = CoordW'(in_ch.point_z);
    in_item.ox = in_ch.offset_x;
    in_item.oy = in_ch.offset_y;
    in_item.oz = in_ch.offset_z;
  end

  eul_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eul_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .scale     (cfg.scale),
    .out_valid (sc_vld),
    .out_ready (sc_rdy),
    .out_item  (sc_item)
  );

  eul_rot u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (AXIS_X),
    .cos_v     (cfg.cos_x),
    .sin_v     (cfg.sin_x),
    .in_valid  (sc_vld),
    .in_ready  (sc_rdy),
    .in_item   (sc_item),
    .out_valid (rx_vld),
    .out_ready (rx_rdy),
    .out_item  (rx_item)
  );

  eul_rot u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (AXIS_Y),
    .cos_v     (cfg.cos_y),
    .sin_v     (cfg.sin_y),
    .in_valid  (rx_vld),
    .in_ready  (rx_rdy),
    .in_item   (rx_item),
    .out_valid (ry_vld),
    .out_ready (ry_rdy),
    .out_item  (ry_item)
  );

  eul_rot u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .axis      (AXIS_Z),
    .cos_v     (cfg.cos_z),
    .sin_v     (cfg.sin_z),
    .in_valid  (ry_vld),
    .in_ready  (ry_rdy),
    .in_item   (ry_item),
    .out_valid (rz_vld),
    .out_ready (rz_rdy),
    .out_item  (rz_item)
  );

  eul_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rz_vld),
    .in_ready  (rz_rdy),
    .in_item   (rz_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_x     (out_ch.result_x),
    .res_y     (out_ch.result_y),
    .res_z     (out_ch.result_z)
  );

endmodule

>>> design/eul_chk.sv
// ---------------------------------------------------------------------------
// Euler rotator port checker
// Watches the stream ports of the rotator and checks flow control and
// word bookkeeping over time.
// ---------------------------------------------------------------------------
`include "euler_xyz_point_rotator_defines.svh"

module eul_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [eul_pkg::PtW-1:0] result_x,
  input logic signed [eul_pkg::PtW-1:0] result_y,
  input logic signed [eul_pkg::PtW-1:0] result_z
);
  import eul_pkg::*;

  logic [CntW-1:0]  cnt_r;
  logic [CntW-1:0]  cnt_nxt;
  logic [3*PtW-1:0] res_w;

  assign res_w = {result_x, result_y, result_z};

  // Words accepted but not yet delivered.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) begin
      cnt_nxt = cnt_nxt + CntW'(1);
    end
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_nxt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `EUL_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result word shown right after reset")
  `EUL_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled without output back-pressure")
  `EUL_ASSERT(a_no_phantom, out_valid |-> cnt_r != '0, "result word without an accepted input word")
  `EUL_ASSERT(a_depth, cnt_r <= CntW'(PipeDepth), "more words in flight than pipeline stages")
  `EUL_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(res_w), "stalled result changed")

endmodule

bind euler_xyz_point_rotator eul_chk u_eul_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .result_x  (out_ch.result_x),
  .result_y  (out_ch.result_y),
  .result_z  (out_ch.result_z)
);
